>>> hw/rtl/c32fd_pkg.sv
// Shared types, constants and the CRC-32C byte update for the frame decoder.
package c32fd_pkg;

  localparam logic [31:0] CRC32C_POLY       = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;
  localparam logic [31:0] HEADER_BYTES      = 32'd8;
  localparam logic [31:0] BODY_START        = 32'd24;
  localparam logic [31:0] FULL_PAYLOAD      = 32'd16;
  localparam logic [31:0] MIN_VERSION_LEN   = 32'd4;
  localparam logic [31:0] EXP_VERSION_RESET = 32'd1;
  localparam logic [31:0] MAX_LEN_RESET     = 32'd16777216;

  // Configuration register indexes
  localparam logic REG_EXPECTED_VERSION = 1'b0;
  localparam logic REG_MAX_PAYLOAD_LEN  = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_OK            = 3'd0,
    VERDICT_SHORT_HEADER  = 3'd1,
    VERDICT_TOO_LONG      = 3'd2,
    VERDICT_LEN_MISMATCH  = 3'd3,
    VERDICT_CRC_BAD       = 3'd4,
    VERDICT_SHORT_PAYLOAD = 3'd5,
    VERDICT_BAD_VERSION   = 3'd6
  } verdict_t;

  typedef struct packed {
    logic        has_result;
    logic [7:0]  body_byte;
    logic        body_valid;
    logic        is_last;
    verdict_t    verdict;
    logic [31:0] frame_kind;
    logic [63:0] request_tag;
  } result_t;

  // Reflected CRC-32C update over one byte, one bit per step.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC32C_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

>>> hw/rtl/c32fd_core.sv
// Frame state, field capture, running CRC and verdict logic for one byte.
module c32fd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                end_of_frame,
  input  logic [31:0]         expected_version,
  input  logic [31:0]         max_payload_len,
  output c32fd_pkg::result_t  result
);
  import c32fd_pkg::*;

  logic [31:0] byte_count_r,   byte_count_nxt;
  logic [31:0] declared_len_r, declared_len_nxt;
  logic [31:0] carried_crc_r,  carried_crc_nxt;
  logic [31:0] running_crc_r,  running_crc_nxt;
  logic [31:0] version_word_r, version_word_nxt;
  logic [31:0] kind_word_r,    kind_word_nxt;
  logic [63:0] request_word_r, request_word_nxt;

  logic [31:0] ins32;
  logic [63:0] ins64;
  logic        is_body;
  logic [32:0] len_sum;
  verdict_t    verdict;

  always_comb begin
    ins32   = {24'h0, data_byte} << {byte_count_r[1:0], 3'b000};
    ins64   = {56'h0, data_byte} << {byte_count_r[2:0], 3'b000};
    is_body = byte_count_r >= BODY_START;

    declared_len_nxt = declared_len_r;
    carried_crc_nxt  = carried_crc_r;
    version_word_nxt = version_word_r;
    kind_word_nxt    = kind_word_r;
    request_word_nxt = request_word_r;
    if (byte_count_r < 32'd4) begin
      declared_len_nxt = declared_len_r | ins32;
    end else if (byte_count_r < HEADER_BYTES) begin
      carried_crc_nxt = carried_crc_r | ins32;
    end else if (byte_count_r < 32'd12) begin
      version_word_nxt = version_word_r | ins32;
    end else if (byte_count_r < FULL_PAYLOAD) begin
      kind_word_nxt = kind_word_r | ins32;
    end else if (!is_body) begin
      request_word_nxt = request_word_r | ins64;
    end

    running_crc_nxt = (byte_count_r >= HEADER_BYTES) ?
                      crc32c_byte(running_crc_r, data_byte) : running_crc_r;
    // Saturate the count at all ones
    byte_count_nxt  = (&byte_count_r) ? byte_count_r : byte_count_r + 32'd1;

    len_sum = {1'b0, declared_len_nxt} + {1'b0, HEADER_BYTES};
    if (byte_count_nxt < HEADER_BYTES) begin
      verdict = VERDICT_SHORT_HEADER;
    end else if (declared_len_nxt > max_payload_len) begin
      verdict = VERDICT_TOO_LONG;
    end else if (len_sum != {1'b0, byte_count_nxt}) begin
      verdict = VERDICT_LEN_MISMATCH;
    end else if (~running_crc_nxt != carried_crc_nxt) begin
      verdict = VERDICT_CRC_BAD;
    end else if (declared_len_nxt < MIN_VERSION_LEN) begin
      verdict = VERDICT_SHORT_PAYLOAD;
    end else if (version_word_nxt != expected_version) begin
      verdict = VERDICT_BAD_VERSION;
    end else if (declared_len_nxt < FULL_PAYLOAD) begin
      verdict = VERDICT_SHORT_PAYLOAD;
    end else begin
      verdict = VERDICT_OK;
    end

    result.has_result  = is_body | end_of_frame;
    result.body_byte   = is_body ? data_byte : 8'h00;
    result.body_valid  = is_body;
    result.is_last     = end_of_frame;
    result.verdict     = end_of_frame ? verdict : VERDICT_OK;
    result.frame_kind  = end_of_frame ? kind_word_nxt : 32'h0;
    result.request_tag = end_of_frame ? request_word_nxt : 64'h0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_frame)) begin
      byte_count_r   <= '0;
      declared_len_r <= '0;
      carried_crc_r  <= '0;
      running_crc_r  <= CRC_INIT;
      version_word_r <= '0;
      kind_word_r    <= '0;
      request_word_r <= '0;
    end else if (step) begin
      byte_count_r   <= byte_count_nxt;
      declared_len_r <= declared_len_nxt;
      carried_crc_r  <= carried_crc_nxt;
      running_crc_r  <= running_crc_nxt;
      version_word_r <= version_word_nxt;
      kind_word_r    <= kind_word_nxt;
      request_word_r <= request_word_nxt;
    end
  end

endmodule

>>> hw/rtl/crc32c_frame_decoder_top.sv
// Top level of the length-prefixed CRC-32C frame decoder.
// Accepts one frame byte per beat and sustains one beat per cycle while the
// result channel is not stalled. Each byte is held in the input register;
// then the frame-state logic (field capture, a byte-wide CRC-32C update and
// the verdict compare) writes the result register, which drives the out_
// ports. While the result register is stalled, the input register holds its
// byte and in_ready drops.
// Header bytes (frame offsets 0..23) give no result unless they end the
// frame; body bytes are passed out as they arrive, before the CRC is known,
// and the final beat carries the verdict, kind and request id. Drop the body
// unless that verdict is ok. Write configuration only while no frame bytes
// are in flight.
module crc32c_frame_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_frame,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_body_byte,
  output logic        out_body_valid,
  output logic        out_is_last,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_frame_kind,
  output logic [63:0] out_request_tag,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import c32fd_pkg::*;

  logic [31:0] expected_version_r;
  logic [31:0] max_payload_len_r;

  logic        in_valid_r;
  logic [7:0]  in_data_r;
  logic        in_eof_r;

  logic        out_valid_r;
  result_t     out_r;
  result_t     core_res;
  logic        s1_adv;

  // Advance the held byte when the result register is free or draining
  assign s1_adv   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || s1_adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_version_r <= EXP_VERSION_RESET;
      max_payload_len_r  <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPECTED_VERSION: expected_version_r <= cfg_wdata;
        REG_MAX_PAYLOAD_LEN:  max_payload_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: hold one byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data_byte;
      in_eof_r  <= in_end_of_frame;
    end
  end

  c32fd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (s1_adv),
    .data_byte        (in_data_r),
    .end_of_frame     (in_eof_r),
    .expected_version (expected_version_r),
    .max_payload_len  (max_payload_len_r),
    .result           (core_res)
  );

  // Result register: load only bytes that produce a result, drop the rest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= core_res.has_result;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && core_res.has_result) begin
      out_r <= core_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_body_byte   = out_r.body_byte;
  assign out_body_valid  = out_r.body_valid;
  assign out_is_last     = out_r.is_last;
  assign out_verdict     = out_r.verdict;
  assign out_frame_kind  = out_r.frame_kind;
  assign out_request_tag = out_r.request_tag;

endmodule

>>> hw/rtl/c32fd_checker.sv
// Port-level checks on the frame decoder's result channel, bound to the top level.
module c32fd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_body_byte,
  input logic        out_body_valid,
  input logic        out_is_last,
  input logic [2:0]  out_verdict,
  input logic [31:0] out_frame_kind,
  input logic [63:0] out_request_tag
);

  // A stalled result beat stays valid and holds its body byte, last flag, verdict and request tag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_body_byte) &&
    $stable(out_is_last) && $stable(out_verdict) && $stable(out_request_tag))
    else $error("result beat changed while stalled");

  // Every result beat is a body byte or a final byte
  a_out_purpose: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_body_valid || out_is_last)
    else $error("result beat with neither body byte nor end of frame");

  // Trailer fields are zero except on the final beat
  a_trailer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> out_verdict == 3'd0 &&
    out_frame_kind == 32'h0 && out_request_tag == 64'h0)
    else $error("trailer fields set on a non-final beat");

  // Body byte is zero when not a body beat, and verdict code is in range
  a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_body_valid || out_body_byte == 8'h00) && out_verdict != 3'd7)
    else $error("stray body byte or unknown verdict");

endmodule

bind crc32c_frame_decoder_top c32fd_checker u_c32fd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_body_byte   (out_body_byte),
  .out_body_valid  (out_body_valid),
  .out_is_last     (out_is_last),
  .out_verdict     (out_verdict),
  .out_frame_kind  (out_frame_kind),
  .out_request_tag (out_request_tag)
);
